### hdl/priority_prefix_rule_classifier_unit_defines.svh
// Assertion macros for the prefix rule classifier.
// Every use expects a clock named clk and a synchronous reset named rst in scope.
`ifndef PRIORITY_PREFIX_RULE_CLASSIFIER_UNIT_DEFINES_SVH
`define PRIORITY_PREFIX_RULE_CLASSIFIER_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PPRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition is followed by its consequence in the next cycle.
`define PPRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/pprc_pkg.sv
// Shared types and constants for the prefix rule classifier.
// No dependencies.
package pprc_pkg;

  localparam int DATA_W   = 64;
  localparam int BITS_W   = 7;
  localparam int LEN_W    = 4;
  localparam int PRIO_W   = 32;
  localparam int VALUE_W  = 32;
  localparam int CFG_W    = 3;

  localparam int DEF_RULE_SLOTS  = 64;
  localparam int DEF_MAX_FIELDS  = 4;
  localparam int DEF_FIELD_BYTES = 8;

  localparam logic [CFG_W-1:0] CFG_FIELDS_RESET = 3'd4;

  localparam logic [1:0] REQ_ADD      = 2'd0;
  localparam logic [1:0] REQ_COMPILE  = 2'd1;
  localparam logic [1:0] REQ_LOOKUP   = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PHASE   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WAIT = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  // One field operand of the comparator.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [BITS_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } fld_t;

endpackage

### hdl/pprc_req_if.sv
// Request channel of the prefix rule classifier.
// Depends on pprc_pkg.
interface pprc_req_if import pprc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic                field_last;
  logic [DATA_W-1:0]   field_data;
  logic [BITS_W-1:0]   field_bits;
  logic [LEN_W-1:0]    field_len_bytes;
  logic signed [PRIO_W-1:0] rule_priority;
  logic [VALUE_W-1:0]  rule_value;

  modport source(output valid, req_type, field_last, field_data, field_bits,
                 field_len_bytes, rule_priority, rule_value, input ready);
  modport sink(input valid, req_type, field_last, field_data, field_bits,
               field_len_bytes, rule_priority, rule_value, output ready);
endinterface

### hdl/pprc_rsp_if.sv
// Response channel of the prefix rule classifier.
// Depends on pprc_pkg.
interface pprc_rsp_if import pprc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               matched;
  logic [VALUE_W-1:0] match_value;

  modport source(output valid, status, matched, match_value, input ready);
  modport sink(input valid, status, matched, match_value, output ready);
endinterface

### hdl/priority_prefix_rule_classifier_unit.sv
// Top level of the priority prefix rule classifier.
// Depends on pprc_pkg, pprc_req_if, pprc_rsp_if, pprc_field_cmp and the defines header.
//
// Rules are written one field per request transfer (add), the table is then
// frozen by a compile transfer, and queries follow one field per transfer
// (lookup). A completed lookup walks every stored rule field by field
// through a single comparator fed from the rule memories, reading one field
// at a time through the one read port of the field memory. The highest
// priority match wins, ties going to the rule added first. While a lookup
// scans, the request side is not ready; a finished response sits in an
// output register, and while it waits unaccepted the request side holds
// off, taking the next request in the cycle that the response transfers.
`include "priority_prefix_rule_classifier_unit_defines.svh"
module priority_prefix_rule_classifier_unit import pprc_pkg::*; #(
  parameter int RULE_SLOTS  = DEF_RULE_SLOTS,
  parameter int MAX_FIELDS  = DEF_MAX_FIELDS,
  parameter int FIELD_BYTES = DEF_FIELD_BYTES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  pprc_req_if.sink         req,
  pprc_rsp_if.source       rsp
);

  localparam int DW  = 8 * FIELD_BYTES;
  localparam int FW  = DW + BITS_W + LEN_W;
  localparam int NFW = $clog2(MAX_FIELDS + 1);
  localparam int PW  = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int CW  = $clog2(RULE_SLOTS + 1);
  localparam int RW  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int AW  = (RULE_SLOTS * MAX_FIELDS > 1) ? $clog2(RULE_SLOTS * MAX_FIELDS) : 1;
  localparam int MW  = NFW + PRIO_W + VALUE_W;
  localparam logic [DATA_W-1:0] WIN =
    (DW >= DATA_W) ? {DATA_W{1'b1}} : ((64'd1 << DW) - 64'd1);

  // Control state
  state_t           state;
  logic [CFG_W-1:0] cfg_fields;
  logic             frozen;
  logic [PW-1:0]    pos;
  logic [CW-1:0]    rule_count;
  logic [AW-1:0]    rule_base;

  // Query store, one entry per field position
  logic [DW-1:0]     q_data [MAX_FIELDS];
  logic [BITS_W-1:0] q_bits [MAX_FIELDS];
  logic [LEN_W-1:0]  q_len  [MAX_FIELDS];
  logic [NFW-1:0]    q_n;

  // Rule memories: fields per rule, and per rule the field count, priority and value
  logic [FW-1:0] fld_mem  [RULE_SLOTS * MAX_FIELDS];
  logic [MW-1:0] meta_mem [RULE_SLOTS];
  logic [FW-1:0] fld_rd;
  logic [MW-1:0] meta_rd;

  // Scan sequencer and compare stage
  logic [RW-1:0] scan_r;
  logic [PW-1:0] scan_i;
  logic [AW-1:0] scan_fa;
  logic [AW-1:0] scan_base;
  logic          p1_v, p1_lf, p1_lr;
  logic [PW-1:0] p1_i;
  logic          ok_acc, found;
  logic signed [PRIO_W-1:0] best_prio;
  logic [VALUE_W-1:0] best_val;

  // Output register
  logic               out_v;
  status_t            out_status;
  logic               out_matched;
  logic [VALUE_W-1:0] out_value;

  logic          acc, slot_free, done, room, fin_go, scan_go;
  logic [NFW-1:0] act;
  logic [DW-1:0] in_data;
  logic          fld_we, meta_we;
  logic          em;
  status_t       em_st;
  logic          em_m;
  logic [VALUE_W-1:0] em_val;
  logic          scan_lf, scan_lr;

  fld_t          cmp_rule, cmp_qry;
  logic          cmp_hit, fok, ok;
  logic [NFW-1:0] m_nf;
  logic signed [PRIO_W-1:0] m_prio;
  logic [VALUE_W-1:0] m_val;

  // Clamp the field count register into 1..MAX_FIELDS
  always_comb begin
    if (cfg_fields == '0) begin
      act = NFW'(1);
    end else if (32'(cfg_fields) > MAX_FIELDS) begin
      act = NFW'(MAX_FIELDS);
    end else begin
      act = NFW'(cfg_fields);
    end
  end

  assign slot_free = !out_v || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign acc       = req.valid && req.ready;
  assign in_data   = DW'(req.field_data & WIN);
  assign done      = req.field_last || (32'(pos) + 1 >= 32'(act));
  assign room      = 32'(rule_count) < RULE_SLOTS;
  assign fin_go    = (state == S_FIN) && slot_free;
  assign scan_go   = acc && (req.req_type == REQ_LOOKUP) && frozen && done &&
                     (rule_count != '0);

  assign fld_we  = acc && (req.req_type == REQ_ADD) && !frozen && room;
  assign meta_we = fld_we && done;

  // Decide the response, if any, raised this cycle
  always_comb begin
    em     = 1'b0;
    em_st  = ST_OK;
    em_m   = 1'b0;
    em_val = '0;
    if (acc) begin
      unique case (req.req_type)
        REQ_COMPILE: em = 1'b1;
        REQ_ADD: begin
          if (frozen) begin
            em    = 1'b1;
            em_st = ST_PHASE;
          end else if (done) begin
            em    = 1'b1;
            em_st = room ? ST_OK : ST_FULL;
          end
        end
        REQ_LOOKUP: begin
          if (!frozen) begin
            em    = 1'b1;
            em_st = ST_PHASE;
          end else if (done && rule_count == '0) begin
            em    = 1'b1;
            em_st = ST_NOMATCH;
          end
        end
        default: em = 1'b0;
      endcase
    end else if (fin_go) begin
      em     = 1'b1;
      em_st  = found ? ST_OK : ST_NOMATCH;
      em_m   = found;
      em_val = found ? best_val : '0;
    end
  end

  assign scan_lf = 32'(scan_i) + 1 >= 32'(act);
  assign scan_lr = 32'(scan_r) + 1 >= 32'(rule_count);

  // Control registers and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cfg_fields <= CFG_FIELDS_RESET;
      frozen     <= 1'b0;
      pos        <= '0;
      rule_count <= '0;
      rule_base  <= '0;
      p1_v       <= 1'b0;
      out_v      <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_fields <= cfg_data;
      end
      if (acc) begin
        unique case (req.req_type)
          REQ_COMPILE: begin
            frozen <= 1'b1;
            pos    <= '0;
          end
          REQ_ADD: begin
            if (!frozen) begin
              pos <= done ? '0 : PW'(32'(pos) + 1);
              if (done && room) begin
                rule_count <= CW'(32'(rule_count) + 1);
                rule_base  <= AW'(32'(rule_base) + MAX_FIELDS);
              end
            end
          end
          REQ_LOOKUP: begin
            if (frozen) begin
              pos <= done ? '0 : PW'(32'(pos) + 1);
            end
          end
          default: pos <= pos;
        endcase
      end
      // Issue one field read a cycle; advance to the next rule after its last field
      p1_v <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (scan_go) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_lf && scan_lr) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (p1_v && p1_lr) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (em) begin
        out_v <= 1'b1;
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // Payload registers: query store, scan counters, best match, response
  always_ff @(posedge clk) begin
    if (acc && req.req_type == REQ_LOOKUP && frozen) begin
      q_data[pos] <= in_data;
      q_bits[pos] <= req.field_bits;
      q_len[pos]  <= req.field_len_bytes;
      if (done) begin
        q_n       <= NFW'(32'(pos) + 1);
        scan_r    <= '0;
        scan_i    <= '0;
        scan_fa   <= '0;
        scan_base <= '0;
        found     <= 1'b0;
        ok_acc    <= 1'b1;
      end
    end
    if (state == S_SCAN) begin
      p1_i  <= scan_i;
      p1_lf <= scan_lf;
      p1_lr <= scan_lf && scan_lr;
      if (scan_lf) begin
        scan_i    <= '0;
        scan_r    <= RW'(32'(scan_r) + 1);
        scan_base <= AW'(32'(scan_base) + MAX_FIELDS);
        scan_fa   <= AW'(32'(scan_base) + MAX_FIELDS);
      end else begin
        scan_i  <= PW'(32'(scan_i) + 1);
        scan_fa <= AW'(32'(scan_fa) + 1);
      end
    end
    // Fold one field result into the current rule; on its last field, rank it
    if (p1_v) begin
      if (p1_lf) begin
        ok_acc <= 1'b1;
        if (ok && (!found || m_prio > best_prio)) begin
          found     <= 1'b1;
          best_prio <= m_prio;
          best_val  <= m_val;
        end
      end else begin
        ok_acc <= ok;
      end
    end
    if (em) begin
      out_status  <= em_st;
      out_matched <= em_m;
      out_value   <= em_val;
    end
  end

  // Rule memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (fld_we) begin
      fld_mem[AW'(32'(rule_base) + 32'(pos))] <=
        {in_data, req.field_bits, req.field_len_bytes};
    end
    fld_rd <= fld_mem[scan_fa];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[rule_count[RW-1:0]] <=
        {NFW'(32'(pos) + 1), req.rule_priority, req.rule_value};
    end
    meta_rd <= meta_mem[scan_r];
  end

  assign m_nf   = meta_rd[MW-1 -: NFW];
  assign m_prio = meta_rd[VALUE_W +: PRIO_W];
  assign m_val  = meta_rd[VALUE_W-1:0];

  always_comb begin
    cmp_rule.data = DATA_W'(fld_rd[FW-1 -: DW]);
    cmp_rule.bits = fld_rd[LEN_W +: BITS_W];
    cmp_rule.len  = fld_rd[LEN_W-1:0];
    cmp_qry.data  = DATA_W'(q_data[p1_i]);
    // Positions past the end of a short query act as wildcards
    cmp_qry.bits  = (32'(p1_i) >= 32'(q_n)) ? '0 : q_bits[p1_i];
    cmp_qry.len   = q_len[p1_i];
  end

  pprc_field_cmp #(
    .FIELD_BYTES(FIELD_BYTES)
  ) u_cmp (
    .rule_fld(cmp_rule),
    .qry_fld (cmp_qry),
    .hit     (cmp_hit)
  );

  // Positions past the end of a short rule match any query
  assign fok = (32'(p1_i) >= 32'(m_nf)) || cmp_hit;
  assign ok  = ok_acc && fok;

  assign rsp.valid       = out_v;
  assign rsp.status      = out_status;
  assign rsp.matched     = out_matched;
  assign rsp.match_value = out_value;

  `PPRC_ASSERT(a_acc_idle, (req.valid && req.ready) |-> (state == S_IDLE), "transfer taken while busy")
  `PPRC_ASSERT(a_count_max, (32'(rule_count) <= RULE_SLOTS), "rule count beyond table size")
  `PPRC_ASSERT_NEXT(a_last_fin, (p1_v && p1_lr), (state == S_FIN), "scan end missed")
  `PPRC_ASSERT(a_pipe_busy, p1_v |-> (state == S_SCAN || state == S_WAIT), "compare outside scan")

endmodule

### hdl/pprc_field_cmp.sv
// Shared field comparator: one rule field against one query field.
// Depends on pprc_pkg.
module pprc_field_cmp import pprc_pkg::*; #(
  parameter int FIELD_BYTES = DEF_FIELD_BYTES
) (
  input  fld_t rule_fld,
  input  fld_t qry_fld,
  output logic hit
);

  localparam int W = 8 * FIELD_BYTES;
  localparam logic [DATA_W-1:0] WIN =
    (W >= DATA_W) ? {DATA_W{1'b1}} : ((64'd1 << W) - 64'd1);

  logic [DATA_W-1:0] mask;

  always_comb begin
    if (32'(rule_fld.bits) >= W) begin
      mask = WIN;
    end else begin
      mask = WIN ^ (WIN >> rule_fld.bits);
    end
  end

  // Wildcard query, or long enough and equal under the prefix mask.
  assign hit = (qry_fld.bits == '0) ||
               (!(qry_fld.len < rule_fld.len) &&
                (((rule_fld.data ^ qry_fld.data) & mask) == '0));

endmodule

### dv/pprc_classifier_checker.sv
// Checker for the prefix rule classifier: watches both channels and the
// register port, predicts each response and compares it. Depends on pprc_pkg
// and the request and response interfaces.
module pprc_classifier_checker import pprc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  pprc_req_if              req,
  pprc_rsp_if              rsp,
  output int               mismatches,
  output int               outstanding
);

  localparam int NR = DEF_RULE_SLOTS;
  localparam int NF = DEF_MAX_FIELDS;

  typedef struct packed {
    status_t            st;
    logic               hit;
    logic [VALUE_W-1:0] val;
  } verdict_t;

  fld_t                       tbl_fld [NR][NF];
  logic signed [PRIO_W-1:0]   tbl_prio [NR];
  logic [VALUE_W-1:0]         tbl_val [NR];
  fld_t                       qry_fld [NF];
  int                         n_rules;
  logic                       locked;
  int                         slot;
  logic [CFG_W-1:0]           width_reg;
  verdict_t                   awaited[$];

  function automatic int live_fields();
    int n;
    n = width_reg;
    if (n == 0) n = 1;
    if (n > NF) n = NF;
    return n;
  endfunction

  function automatic logic field_hit(fld_t r, fld_t q);
    logic [DATA_W-1:0] m;
    if (q.bits == 0) return 1'b1;
    if (q.len < r.len) return 1'b0;
    m = (r.bits >= DATA_W) ? '1 : ~({DATA_W{1'b1}} >> r.bits);
    return ((r.data ^ q.data) & m) == '0;
  endfunction

  // Advance the classifier state by one transfer; return 1 if it answers.
  function automatic logic classify(input logic [1:0] kind, input logic last,
                                    input fld_t f, input logic signed [PRIO_W-1:0] pr,
                                    input logic [VALUE_W-1:0] v, output verdict_t o);
    int p;
    logic done, room, ok, found;
    logic signed [PRIO_W-1:0] best_p;
    o = '{ST_OK, 1'b0, '0};
    if (kind == REQ_COMPILE) begin
      locked = 1'b1;
      slot = 0;
      return 1'b1;
    end
    if (kind != REQ_ADD && kind != REQ_LOOKUP) return 1'b0;
    if ((kind == REQ_ADD && locked) || (kind == REQ_LOOKUP && !locked)) begin
      o.st = ST_PHASE;
      return 1'b1;
    end
    p = (slot >= NF) ? NF - 1 : slot;
    done = last || (p + 1 >= live_fields());
    if (kind == REQ_ADD) begin
      room = n_rules < NR;
      if (room) tbl_fld[n_rules][p] = f;
      if (!done) begin
        slot = p + 1;
        return 1'b0;
      end
      slot = 0;
      if (!room) begin
        o.st = ST_FULL;
        return 1'b1;
      end
      for (int i = p + 1; i < NF; i++) tbl_fld[n_rules][i] = '0;
      tbl_prio[n_rules] = pr;
      tbl_val[n_rules] = v;
      n_rules++;
      return 1'b1;
    end
    qry_fld[p] = f;
    if (!done) begin
      slot = p + 1;
      return 1'b0;
    end
    slot = 0;
    for (int i = p + 1; i < NF; i++) qry_fld[i] = '0;
    found = 1'b0;
    best_p = '0;
    for (int r = 0; r < n_rules; r++) begin
      ok = 1'b1;
      for (int i = 0; i < live_fields(); i++)
        if (!field_hit(tbl_fld[r][i], qry_fld[i])) ok = 1'b0;
      // strict compare keeps the earlier rule on a tie
      if (ok && (!found || tbl_prio[r] > best_p)) begin
        found = 1'b1;
        best_p = tbl_prio[r];
        o.val = tbl_val[r];
      end
    end
    if (found) o.hit = 1'b1;
    else o.st = ST_NOMATCH;
    return 1'b1;
  endfunction

  assign outstanding = awaited.size();

  always @(posedge clk) begin
    verdict_t exp_v, got;
    fld_t f;
    if (rst) begin
      n_rules = 0;
      locked = 1'b0;
      slot = 0;
      width_reg = CFG_FIELDS_RESET;
      mismatches = 0;
      awaited.delete();
    end else begin
      if (cfg_we) width_reg = cfg_data;
      if (req.valid && req.ready) begin
        f = '{req.field_data, req.field_bits, req.field_len_bytes};
        if (classify(req.req_type, req.field_last, f, req.rule_priority,
                     req.rule_value, exp_v))
          awaited.push_back(exp_v);
      end
      if (rsp.valid && rsp.ready) begin
        got = '{status_t'(rsp.status), rsp.matched, rsp.match_value};
        if (awaited.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected response st=%0d hit=%0d val=%h",
                     got.st, got.hit, got.val);
          mismatches = mismatches + 1;
        end else begin
          exp_v = awaited.pop_front();
          if (got !== exp_v) begin
            if (mismatches < 10)
              $display("response mismatch: exp st=%0d hit=%0d val=%h, got st=%0d hit=%0d val=%h",
                       exp_v.st, exp_v.hit, exp_v.val, got.st, got.hit, got.val);
            mismatches = mismatches + 1;
          end
        end
      end
    end
  end

endmodule

### dv/tb_top.sv
// Top of the prefix rule classifier testbench: clock, reset, stimulus and
// verdict. Depends on pprc_pkg, the channel interfaces, the block and the checker.
module tb_top;
  import pprc_pkg::*;

  // Slack after the last response: one full scan of the table and some margin.
  localparam int SCAN_SLACK = 300;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  int               mismatches;
  int               outstanding;
  logic             calm = 1'b0;   // set during the stretch with no idling
  logic [DATA_W-1:0] seen_data[$]; // rule field data kept to aim queries at rules

  pprc_req_if req();
  pprc_rsp_if rsp();

  priority_prefix_rule_classifier_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  pprc_classifier_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req), .rsp(rsp), .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Response back-pressure: stall about 17 percent of the time, never when calm.
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= calm || ($urandom_range(99) >= 17);
  end

  // Present one request and hold it until the transfer; call at a rising edge.
  task automatic push(input logic [1:0] kind, input logic last, input logic [DATA_W-1:0] d,
                      input logic [BITS_W-1:0] b, input logic [LEN_W-1:0] l,
                      input logic [PRIO_W-1:0] pr, input logic [VALUE_W-1:0] v);
    if (!calm && $urandom_range(99) < 17) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.field_last <= last;
    req.field_data <= d;
    req.field_bits <= b;
    req.field_len_bytes <= l;
    req.rule_priority <= pr;
    req.rule_value <= v;
    @(negedge clk);
    while (!req.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop valid, wait out every response plus one scan, then write the register.
  task automatic set_width(input logic [CFG_W-1:0] w);
    int guard;
    req.valid <= 1'b0;
    guard = 0;
    while (outstanding != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SCAN_SLACK) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [BITS_W-1:0] rnd_bits();
    if ($urandom_range(99) < 20) return BITS_W'($urandom_range(127, 65));
    return BITS_W'($urandom_range(64));
  endfunction

  function automatic logic [LEN_W-1:0] rnd_len();
    if ($urandom_range(99) < 15) return LEN_W'($urandom_range(15, 9));
    return LEN_W'($urandom_range(8));
  endfunction

  // Priorities: half the time one of -1 to 2 so that ties happen, else full range.
  function automatic logic [PRIO_W-1:0] rnd_prio();
    if ($urandom_range(1)) return PRIO_W'($urandom_range(3)) - 32'd1;
    return $urandom;
  endfunction

  // One rule of random content, sometimes cut short, sometimes with noise.
  task automatic random_rule(input int n);
    logic [DATA_W-1:0] d;
    logic last;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) push(REQ_RESERVED, 1'($urandom), rnd64(), rnd_bits(),
                                       rnd_len(), $urandom, $urandom);
      d = rnd64();
      seen_data.push_back(d);
      last = (i == n - 1) || ($urandom_range(99) < 10);
      push(REQ_ADD, last, d, rnd_bits(), rnd_len(), rnd_prio(), $urandom);
      if (last) break;
    end
  endtask

  // One query, most fields taken from stored rules with low bits disturbed.
  task automatic random_query(input int n);
    logic [DATA_W-1:0] d;
    logic [BITS_W-1:0] b;
    logic last;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80 && seen_data.size() > 0) begin
        d = seen_data[$urandom_range(seen_data.size() - 1)];
        d = d ^ (rnd64() >> $urandom_range(64, 20));
      end else d = rnd64();
      b = ($urandom_range(99) < 20) ? '0 : rnd_bits();
      last = (i == n - 1) || ($urandom_range(99) < 8);
      push(REQ_LOOKUP, last, d, b, rnd_len(), $urandom, $urandom);
      if (last) break;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] widths[7];
    int guard;
    req.valid <= 1'b0;
    req.req_type <= REQ_ADD;
    req.field_last <= 1'b0;
    req.field_data <= '0;
    req.field_bits <= '0;
    req.field_len_bytes <= '0;
    req.rule_priority <= '0;
    req.rule_value <= '0;
    widths = '{3'd4, 3'd1, 3'd2, 3'd0, 3'd3, 3'd7, 3'd5};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: wrong phase, ignored request, extreme fields and ties.
    push(REQ_LOOKUP, 1'b1, '1, 7'd64, 4'd8, '0, '0);
    push(REQ_RESERVED, 1'b1, '1, '1, '1, '1, '1);
    push(REQ_ADD, 1'b0, '1, 7'd64, 4'd8, '0, '0);
    push(REQ_ADD, 1'b0, '0, 7'd0, 4'd0, '0, '0);
    push(REQ_ADD, 1'b0, 64'h8000_0000_0000_0001, 7'd127, 4'd15, '0, '0);
    push(REQ_ADD, 1'b1, 64'h0123_4567_89ab_cdef, 7'd1, 4'd0, 32'h7fff_ffff, '1);
    push(REQ_ADD, 1'b1, '1, 7'd8, 4'd1, 32'h8000_0000, 32'h1);
    push(REQ_ADD, 1'b1, 64'hff00_0000_0000_0000, 7'd8, 4'd1, 32'h8000_0000, 32'h2);
    push(REQ_ADD, 1'b0, 64'hdead_beef_0000_0000, 7'd32, 4'd4, '0, '0);
    push(REQ_ADD, 1'b1, 64'h5555_5555_5555_5555, 7'd63, 4'd8, 32'd5, 32'haaaa_5555);
    seen_data.push_back('1);
    seen_data.push_back(64'hdead_beef_0000_0000);

    // Random rules across several widths, enough to overflow the table.
    for (int ph = 0; ph < 7; ph++) begin
      set_width(widths[ph]);
      if (ph == 2) calm = 1'b1;
      for (int r = 0; r < 10; r++) random_rule(4);
      calm = 1'b0;
    end

    // Freeze, freeze again, add after compile, then two fixed lookups.
    push(REQ_COMPILE, 1'b0, rnd64(), rnd_bits(), rnd_len(), $urandom, $urandom);
    push(REQ_COMPILE, 1'b1, rnd64(), rnd_bits(), rnd_len(), $urandom, $urandom);
    push(REQ_ADD, 1'b1, rnd64(), rnd_bits(), rnd_len(), $urandom, $urandom);
    push(REQ_LOOKUP, 1'b1, '1, 7'd0, 4'd0, '0, '0);
    push(REQ_LOOKUP, 1'b1, '1, 7'd8, 4'd15, '0, '0);

    // Random queries across all seven listed widths, one stretch without idling.
    for (int ph = 0; ph < 7; ph++) begin
      set_width(widths[(ph + 3) % 7]);
      if (ph == 4) calm = 1'b1;
      for (int q = 0; q < 11; q++) begin
        if ($urandom_range(99) < 4) push(REQ_ADD, 1'b1, rnd64(), rnd_bits(), rnd_len(),
                                         $urandom, $urandom);
        random_query(4);
      end
      calm = 1'b0;
    end
    set_width(3'd4);
    for (int q = 0; q < 8; q++) random_query(4);

    // Drain and give the verdict.
    req.valid <= 1'b0;
    guard = 0;
    while (outstanding != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SCAN_SLACK) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hold a hard ceiling on the run in case the handshake hangs.
  initial begin
    #12000000;
    $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/pprc_pkg.sv
hdl/pprc_req_if.sv
hdl/pprc_rsp_if.sv
hdl/pprc_field_cmp.sv
hdl/priority_prefix_rule_classifier_unit.sv
dv/pprc_classifier_checker.sv
dv/tb_top.sv
